// ===== rtl/crt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int EDGE_DEPTH_DEF  = 4096;
    localparam int TRACE_DEPTH_DEF = 65536;

    localparam int CMD_W    = 2;
    localparam int GIDX_W   = 12;
    localparam int PC_W     = 32;
    localparam int RIDX_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 17;
    localparam int HIT_W    = 8;
    localparam int MODE_W   = 2;
    localparam int ECNT_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int IDX_EXT_W  = 32;

    localparam logic [HIT_W-1:0]   HIT_MAX         = 8'd255;
    localparam logic [COUNT_W-1:0] TRACE_LIMIT_RST = 17'd65536;
    localparam logic [ECNT_W-1:0]  EDGE_COUNT_RST  = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_EVENT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_TRACE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_HITS  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_PC    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_TRACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACHED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT  = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              seen;
        logic [PC_W-1:0]   pc;
        logic [HIT_W-1:0]  hits;
    } t_edge_word;

endpackage

`default_nettype wire

// ===== rtl/coverage_trace_recorder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  handshake               payload
// in         to block   i_in_valid / o_in_stall  cmd, guard_present, guard_index, pc_offset,
//                                                in_interrupt, read_index
// out        from block o_out_valid / i_out_stall status, read_data, trace_count
// cfg        to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a request is handled in steps: the edge memory and trace memory are read as it is taken,
// then the entry is modified and written back and the result register is loaded
// the next request is taken while a result waits; it holds in its write-back step
// until the result register is free
// after reset a clearing pass zeroes every entry of the edge memory;
// no request is taken during it, configuration writes are

module coverage_trace_recorder_unit #(
    parameter int EDGE_DEPTH  = crt_pkg::EDGE_DEPTH_DEF,
    parameter int TRACE_DEPTH = crt_pkg::TRACE_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,

    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [crt_pkg::CMD_W-1:0]       i_cmd,
    input  wire                             i_guard_present,
    input  wire  [crt_pkg::GIDX_W-1:0]      i_guard_index,
    input  wire  [crt_pkg::PC_W-1:0]        i_pc_offset,
    input  wire                             i_in_interrupt,
    input  wire  [crt_pkg::RIDX_W-1:0]      i_read_index,

    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [crt_pkg::STATUS_W-1:0]    o_status,
    output logic [crt_pkg::PC_W-1:0]        o_read_data,
    output logic [crt_pkg::COUNT_W-1:0]     o_trace_count,

    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [crt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [crt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import crt_pkg::*;

    localparam int EW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int TW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam logic [IDX_EXT_W-1:0] EDGE_LIM  = IDX_EXT_W'(EDGE_DEPTH);
    localparam logic [IDX_EXT_W-1:0] TRACE_LIM = IDX_EXT_W'(TRACE_DEPTH);
    localparam logic [EW-1:0]        CLR_LAST  = EW'(EDGE_DEPTH - 1);

    t_edge_word        edge_mem [EDGE_DEPTH];
    logic [PC_W-1:0]   trace_mem [TRACE_DEPTH];

    t_state r_state, n_state;
    logic [EW-1:0] r_clr_addr;

    logic [MODE_W-1:0]  r_mode;
    logic               r_enabled;
    logic               r_attached;
    logic [COUNT_W-1:0] r_trace_limit;
    logic [ECNT_W-1:0]  r_edge_count;
    logic [COUNT_W-1:0] r_trace_head, n_trace_head;

    // latched request
    logic [CMD_W-1:0]   r_cmd;
    logic               r_present;
    logic [GIDX_W-1:0]  r_gidx;
    logic [PC_W-1:0]    r_pc;
    logic               r_irq;
    logic [RIDX_W-1:0]  r_ridx;

    t_edge_word         r_edge_rd;
    logic [PC_W-1:0]    r_trace_rd;

    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [PC_W-1:0]    r_read_data;
    logic [COUNT_W-1:0] r_trace_count;

    logic               accept;
    logic               fire;
    logic [IDX_EXT_W-1:0] in_gidx_ext, in_ridx_ext, gidx_ext, ridx_ext, head_ext;
    logic [IDX_EXT_W-1:0] trace_lim_eff;
    logic [EW-1:0]      edge_raddr;
    logic               edge_ok, map_upd, record, trace_rec, count_inc;
    logic               edge_we;
    logic [EW-1:0]      edge_waddr;
    t_edge_word         edge_wdata;
    logic               trace_we;
    logic [STATUS_W-1:0] res_status;
    logic [PC_W-1:0]    res_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign fire        = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign in_gidx_ext = IDX_EXT_W'(i_guard_index);
    assign in_ridx_ext = IDX_EXT_W'(i_read_index);
    assign edge_raddr  = (i_cmd == CMD_EVENT) ? in_gidx_ext[EW-1:0] : in_ridx_ext[EW-1:0];

    assign gidx_ext = IDX_EXT_W'(r_gidx);
    assign ridx_ext = IDX_EXT_W'(r_ridx);
    assign head_ext = IDX_EXT_W'(r_trace_head);
    assign trace_lim_eff = (IDX_EXT_W'(r_trace_limit) > TRACE_LIM) ?
                           TRACE_LIM : IDX_EXT_W'(r_trace_limit);

    always_comb begin
        edge_ok   = gidx_ext < EDGE_LIM;
        map_upd   = (r_cmd == CMD_EVENT) && r_present && (r_gidx != '0)
                    && (gidx_ext < IDX_EXT_W'(r_edge_count))
                    && edge_ok && !r_edge_rd.seen;
        record    = r_attached && !r_irq && r_enabled;
        trace_rec = 1'b0;
        count_inc = 1'b0;
        res_status = ST_RANGE;
        res_data   = '0;

        case (r_cmd)
            CMD_EVENT: begin
                res_status = ST_IGNORED;
                if (record && r_mode == MODE_TRACE) begin
                    if (head_ext >= trace_lim_eff) begin
                        res_status = ST_FULL;
                    end else begin
                        res_status = ST_DONE;
                        trace_rec  = 1'b1;
                    end
                end else if (record && r_mode == MODE_COUNT && r_present && edge_ok) begin
                    res_status = ST_DONE;
                    count_inc  = (r_edge_rd.hits != HIT_MAX);
                end
            end
            CMD_READ_TRACE: begin
                if (ridx_ext < head_ext && ridx_ext < TRACE_LIM) begin
                    res_status = ST_DONE;
                    res_data   = r_trace_rd;
                end
            end
            CMD_READ_HITS: begin
                if (ridx_ext < EDGE_LIM) begin
                    res_status = ST_DONE;
                    res_data   = PC_W'(r_edge_rd.hits);
                end
            end
            CMD_READ_PC: begin
                if (ridx_ext < EDGE_LIM) begin
                    res_status = ST_DONE;
                    res_data   = r_edge_rd.pc;
                end
            end
            default: begin
                res_status = ST_RANGE;
            end
        endcase

        n_trace_head = r_trace_head + COUNT_W'(trace_rec);
        trace_we     = fire && trace_rec;
    end

    // write port of the edge memory: clearing pass or read-modify-write
    always_comb begin
        edge_we    = 1'b0;
        edge_waddr = r_clr_addr;
        edge_wdata = '0;
        if (r_state == S_CLEAR) begin
            edge_we = 1'b1;
        end else if (fire && (map_upd || count_inc)) begin
            edge_we         = 1'b1;
            edge_waddr      = gidx_ext[EW-1:0];
            edge_wdata.seen = r_edge_rd.seen | map_upd;
            edge_wdata.pc   = map_upd ? r_pc : r_edge_rd.pc;
            edge_wdata.hits = r_edge_rd.hits + HIT_W'(count_inc);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + EW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_enabled     <= 1'b0;
            r_attached    <= 1'b0;
            r_trace_limit <= TRACE_LIMIT_RST;
            r_edge_count  <= EDGE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MODE:        r_mode        <= i_cfg_data[MODE_W-1:0];
                REG_ENABLED:     r_enabled     <= i_cfg_data[0];
                REG_ATTACHED:    r_attached    <= i_cfg_data[0];
                REG_TRACE_LIMIT: r_trace_limit <= i_cfg_data[COUNT_W-1:0];
                REG_EDGE_COUNT:  r_edge_count  <= i_cfg_data[ECNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_head <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_trace_head <= n_trace_head;
            end
            r_out_valid <= fire || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_present <= i_guard_present;
            r_gidx    <= i_guard_index;
            r_pc      <= i_pc_offset;
            r_irq     <= i_in_interrupt;
            r_ridx    <= i_read_index;
        end
        if (fire) begin
            r_status      <= res_status;
            r_read_data   <= res_data;
            r_trace_count <= n_trace_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_edge_rd <= edge_mem[edge_raddr];
        end
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_trace_rd <= trace_mem[in_ridx_ext[TW-1:0]];
        end
        if (trace_we) begin
            trace_mem[head_ext[TW-1:0]] <= r_pc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_trace_count = r_trace_count;

endmodule

`default_nettype wire

// ===== dv/coverage_trace_recorder_unit_chk.sv =====
`timescale 1ns / 1ps

module coverage_trace_recorder_unit_chk #(
    parameter int EDGE_DEPTH  = crt_pkg::EDGE_DEPTH_DEF,
    parameter int TRACE_DEPTH = crt_pkg::TRACE_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,

    input  wire                             i_in_valid,
    input  wire                             i_in_stall,
    input  wire  [crt_pkg::CMD_W-1:0]       i_cmd,
    input  wire                             i_guard_present,
    input  wire  [crt_pkg::GIDX_W-1:0]      i_guard_index,
    input  wire  [crt_pkg::PC_W-1:0]        i_pc_offset,
    input  wire                             i_in_interrupt,
    input  wire  [crt_pkg::RIDX_W-1:0]      i_read_index,

    input  wire                             i_out_valid,
    input  wire                             i_out_stall,
    input  wire  [crt_pkg::STATUS_W-1:0]    i_status,
    input  wire  [crt_pkg::PC_W-1:0]        i_read_data,
    input  wire  [crt_pkg::COUNT_W-1:0]     i_trace_count,

    input  wire                             i_cfg_valid,
    input  wire                             i_cfg_ready,
    input  wire  [crt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [crt_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    output int                              o_mismatches,
    output int                              o_pending
);

    import crt_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              guard_present;
        logic [GIDX_W-1:0] guard_index;
        logic [PC_W-1:0]   pc_offset;
        logic              in_interrupt;
        logic [RIDX_W-1:0] read_index;
    } t_cov_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PC_W-1:0]     read_data;
        logic [COUNT_W-1:0]  trace_count;
    } t_cov_result;

    // register copies
    logic [MODE_W-1:0]  cfg_mode;
    logic               cfg_enabled;
    logic               cfg_attached;
    logic [COUNT_W-1:0] cfg_trace_limit;
    logic [ECNT_W-1:0]  cfg_edge_count;

    // recorder state
    logic               seen_map  [EDGE_DEPTH];
    logic [PC_W-1:0]    pc_map    [EDGE_DEPTH];
    logic [HIT_W-1:0]   hit_ctr   [EDGE_DEPTH];
    logic [PC_W-1:0]    trace_buf [TRACE_DEPTH];
    logic [COUNT_W-1:0] head;

    t_cov_result  outcome_queue[$];
    t_cov_request req_now;
    t_cov_result  got;
    t_cov_result  want;
    int           mismatch_count = 0;
    int           result_no = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_cov_result recorder_outcome(input t_cov_request rq);
        t_cov_result res;
        int unsigned lim;
        res.status    = ST_RANGE;
        res.read_data = '0;
        if (rq.cmd == CMD_EVENT) begin
            // first sighting of an edge maps its pc, whatever the recording state
            if (rq.guard_present && rq.guard_index != 0 && rq.guard_index < cfg_edge_count
                    && rq.guard_index < EDGE_DEPTH && !seen_map[rq.guard_index]) begin
                pc_map[rq.guard_index]   = rq.pc_offset;
                seen_map[rq.guard_index] = 1'b1;
            end
            lim = (cfg_trace_limit > TRACE_DEPTH) ? TRACE_DEPTH : cfg_trace_limit;
            if (!cfg_attached || rq.in_interrupt || !cfg_enabled) begin
                res.status = ST_IGNORED;
            end else if (cfg_mode == MODE_TRACE) begin
                if (head >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    trace_buf[head] = rq.pc_offset;
                    head            = head + 1'b1;
                    res.status      = ST_DONE;
                end
            end else if (cfg_mode == MODE_COUNT) begin
                if (!rq.guard_present || rq.guard_index >= EDGE_DEPTH) begin
                    res.status = ST_IGNORED;
                end else begin
                    if (hit_ctr[rq.guard_index] != HIT_MAX) begin
                        hit_ctr[rq.guard_index] = hit_ctr[rq.guard_index] + 1'b1;
                    end
                    res.status = ST_DONE;
                end
            end else begin
                res.status = ST_IGNORED;
            end
        end else if (rq.cmd == CMD_READ_TRACE) begin
            if (rq.read_index < head && rq.read_index < TRACE_DEPTH) begin
                res.read_data = trace_buf[rq.read_index];
                res.status    = ST_DONE;
            end
        end else if (rq.read_index < EDGE_DEPTH) begin
            res.read_data = (rq.cmd == CMD_READ_HITS) ? PC_W'(hit_ctr[rq.read_index])
                                                      : pc_map[rq.read_index];
            res.status    = ST_DONE;
        end
        res.trace_count = head;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode        = '0;
            cfg_enabled     = 1'b0;
            cfg_attached    = 1'b0;
            cfg_trace_limit = TRACE_LIMIT_RST;
            cfg_edge_count  = EDGE_COUNT_RST;
            foreach (seen_map[i]) begin
                seen_map[i] = 1'b0;
                pc_map[i]   = '0;
                hit_ctr[i]  = '0;
            end
            head = '0;
            outcome_queue.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_read_data, i_trace_count};
                if (outcome_queue.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              result_no));
                end else begin
                    want = outcome_queue.pop_front();
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  result_no, got.status, want.status));
                    end
                    if (got.read_data !== want.read_data) begin
                        report_mismatch($sformatf("result %0d read_data %h, expected %h",
                                                  result_no, got.read_data, want.read_data));
                    end
                    if (got.trace_count !== want.trace_count) begin
                        report_mismatch($sformatf("result %0d trace_count %0d, expected %0d",
                                                  result_no, got.trace_count,
                                                  want.trace_count));
                    end
                end
                result_no++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:        cfg_mode        = i_cfg_data[MODE_W-1:0];
                    REG_ENABLED:     cfg_enabled     = i_cfg_data[0];
                    REG_ATTACHED:    cfg_attached    = i_cfg_data[0];
                    REG_TRACE_LIMIT: cfg_trace_limit = i_cfg_data[COUNT_W-1:0];
                    REG_EDGE_COUNT:  cfg_edge_count  = i_cfg_data[ECNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                req_now = '{i_cmd, i_guard_present, i_guard_index, i_pc_offset,
                            i_in_interrupt, i_read_index};
                outcome_queue.push_back(recorder_outcome(req_now));
            end
            o_pending <= outcome_queue.size();
        end
    end

endmodule

// ===== dv/coverage_trace_recorder_unit_test.sv =====
`timescale 1ns / 1ps

module coverage_trace_recorder_unit_test;

    import crt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [MODE_W-1:0]    MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0]    MODE_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      cmd           = CMD_EVENT;
    logic                  guard_present = 1'b0;
    logic [GIDX_W-1:0]     guard_index   = '0;
    logic [PC_W-1:0]       pc_offset     = '0;
    logic                  in_interrupt  = 1'b0;
    logic [RIDX_W-1:0]     read_index    = '0;

    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [PC_W-1:0]       read_data;
    logic [COUNT_W-1:0]    trace_count;

    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int                    fail_count;
    int                    pending_count;
    int unsigned           quiet_cycles  = 0;
    int unsigned           stall_hold    = 0;
    int unsigned           stall_pick;
    logic [COUNT_W-1:0]    last_trace_count = '0;
    logic [GIDX_W-1:0]     hot_edge;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    coverage_trace_recorder_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_guard_present (guard_present),
        .i_guard_index   (guard_index),
        .i_pc_offset     (pc_offset),
        .i_in_interrupt  (in_interrupt),
        .i_read_index    (read_index),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_read_data     (read_data),
        .o_trace_count   (trace_count),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    coverage_trace_recorder_unit_chk recorder_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_guard_present (guard_present),
        .i_guard_index   (guard_index),
        .i_pc_offset     (pc_offset),
        .i_in_interrupt  (in_interrupt),
        .i_read_index    (read_index),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_read_data     (read_data),
        .i_trace_count   (trace_count),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (fail_count),
        .o_pending       (pending_count)
    );

    // result side back-pressure: short runs and stalls, now and then a long one
    always @(posedge clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50) begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(0, 7);
            end else if (stall_pick < 85) begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(0, 2);
            end else if (stall_pick < 93) begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(20, 60);
            end else begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            last_trace_count <= trace_count;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned gap_cycles(input bit burst);
        int unsigned pick;
        if (burst) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays high from one register write to the next
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] m, input logic en, input logic att,
                              input logic [COUNT_W-1:0] lim, input logic [ECNT_W-1:0] ecnt);
        write_reg(REG_MODE, CFG_DATA_W'(m));
        write_reg(REG_ENABLED, CFG_DATA_W'(en));
        write_reg(REG_ATTACHED, CFG_DATA_W'(att));
        write_reg(REG_TRACE_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_EDGE_COUNT, CFG_DATA_W'(ecnt));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    task automatic send_req(input logic [CMD_W-1:0] c, input logic pres,
                            input logic [GIDX_W-1:0] g, input logic [PC_W-1:0] pc,
                            input logic irq, input logic [RIDX_W-1:0] r, input bit burst);
        int unsigned gap;
        gap = gap_cycles(burst);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd           <= c;
        guard_present <= pres;
        guard_index   <= g;
        pc_offset     <= pc;
        in_interrupt  <= irq;
        read_index    <= r;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random(input bit hammer, input bit burst);
        logic [CMD_W-1:0]  c;
        logic              pres;
        logic [GIDX_W-1:0] g;
        logic [PC_W-1:0]   pc;
        logic              irq;
        logic [RIDX_W-1:0] r;
        int unsigned       pick;
        // fields unused by a command still carry random values
        pres = 1'($urandom);
        g    = GIDX_W'($urandom);
        pc   = $urandom;
        irq  = ($urandom_range(0, 9) == 0);
        r    = RIDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (hammer) begin
            // drive one edge's counter into saturation
            if (pick < 95) begin
                c    = CMD_EVENT;
                pres = 1'b1;
                g    = hot_edge;
                irq  = 1'b0;
            end else begin
                c = CMD_READ_HITS;
                r = RIDX_W'(hot_edge);
            end
        end else begin
            if (pick < 58) c = CMD_EVENT;
            else if (pick < 72) c = CMD_READ_TRACE;
            else if (pick < 86) c = CMD_READ_HITS;
            else c = CMD_READ_PC;
            pres = ($urandom_range(0, 99) < 85);
            pick = $urandom_range(0, 99);
            if (c == CMD_EVENT) begin
                if (pick < 50) g = GIDX_W'($urandom_range(0, 15));
                else if (pick < 65) g = hot_edge;
            end else if (c == CMD_READ_TRACE) begin
                if (pick < 70) r = RIDX_W'($urandom_range(0, last_trace_count));
                else if (pick < 85) r = last_trace_count[RIDX_W-1:0];
            end else begin
                if (pick < 45) r = RIDX_W'($urandom_range(0, 15));
                else if (pick < 55) r = RIDX_W'(hot_edge);
                else if (pick < 75) r = RIDX_W'($urandom_range(0, EDGE_DEPTH_DEF - 1));
                else if (pick < 80) r = RIDX_W'(EDGE_DEPTH_DEF - 1);
                else if (pick < 85) r = RIDX_W'(EDGE_DEPTH_DEF);
                else if (pick < 88) r = '1;
            end
        end
        send_req(c, pres, g, pc, irq, r, burst);
    endtask

    task automatic run_phase(input int n, input bit burst, input bit hammer);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                drain_results();
            end
            send_random(hammer, burst);
        end
    endtask

    initial begin
        hot_edge = GIDX_W'($urandom_range(1, EDGE_DEPTH_DEF - 2));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // registers are writable during the clearing pass
        write_reg(REG_UNUSED, '1);
        set_config(MODE_TRACE, 1'b1, 1'b1, TRACE_LIMIT_RST, EDGE_COUNT_RST);

        send_req(CMD_EVENT, 1'b1, 12'd1, 32'hffff_ffff, 1'b0, '0, 1'b0);
        send_req(CMD_EVENT, 1'b1, 12'd4095, 32'h0000_0000, 1'b0, '0, 1'b0);
        send_req(CMD_EVENT, 1'b1, 12'd0, 32'h1234_5678, 1'b0, '0, 1'b0);
        send_req(CMD_EVENT, 1'b0, 12'd7, 32'ha5a5_a5a5, 1'b0, '0, 1'b0);
        send_req(CMD_EVENT, 1'b1, 12'd1, 32'h0000_0000, 1'b1, '0, 1'b0);
        // interrupt event still maps a new edge
        send_req(CMD_EVENT, 1'b1, 12'd2, 32'h5a5a_5a5a, 1'b1, '0, 1'b0);
        send_req(CMD_READ_TRACE, 1'b0, '0, '0, 1'b0, 16'd0, 1'b0);
        send_req(CMD_READ_TRACE, 1'b0, '0, '0, 1'b0, 16'd3, 1'b0);
        send_req(CMD_READ_TRACE, 1'b0, '0, '0, 1'b0, 16'd4, 1'b0);
        send_req(CMD_READ_TRACE, 1'b0, '0, '0, 1'b0, 16'hffff, 1'b0);
        send_req(CMD_READ_PC, 1'b0, '0, '0, 1'b0, 16'd1, 1'b0);
        send_req(CMD_READ_PC, 1'b0, '0, '0, 1'b0, 16'd2, 1'b0);
        send_req(CMD_READ_PC, 1'b0, '0, '0, 1'b0, 16'd4095, 1'b0);
        send_req(CMD_READ_PC, 1'b0, '0, '0, 1'b0, 16'd4096, 1'b0);
        send_req(CMD_READ_PC, 1'b0, '0, '0, 1'b0, 16'hffff, 1'b0);
        send_req(CMD_READ_HITS, 1'b0, '0, '0, 1'b0, 16'd0, 1'b0);
        send_req(CMD_READ_HITS, 1'b0, '0, '0, 1'b0, 16'd4095, 1'b0);

        drain_results();
        set_config(MODE_COUNT, 1'b1, 1'b1, TRACE_LIMIT_RST, EDGE_COUNT_RST);
        send_req(CMD_EVENT, 1'b1, 12'd0, 32'hdead_beef, 1'b0, '0, 1'b0);
        send_req(CMD_EVENT, 1'b0, 12'd3, 32'h0bad_f00d, 1'b0, '0, 1'b0);
        send_req(CMD_EVENT, 1'b1, 12'd4095, 32'hffff_ffff, 1'b0, '0, 1'b0);
        send_req(CMD_READ_HITS, 1'b0, '0, '0, 1'b0, 16'd0, 1'b0);
        send_req(CMD_READ_HITS, 1'b0, '0, '0, 1'b0, 16'd4095, 1'b0);
        send_req(CMD_READ_HITS, 1'b0, '0, '0, 1'b0, 16'd4096, 1'b0);

        run_phase(290, 1'b0, 1'b1);

        drain_results();
        set_config(MODE_TRACE, 1'b1, 1'b1,
                   last_trace_count + COUNT_W'($urandom_range(0, 12)), 13'd12);
        run_phase(30, 1'b0, 1'b0);

        drain_results();
        set_config(MODE_OFF, 1'b1, 1'b1, TRACE_LIMIT_RST, 13'd0);
        run_phase(10, 1'b1, 1'b0);

        drain_results();
        set_config(MODE_TRACE, 1'b0, 1'b1, TRACE_LIMIT_RST, EDGE_COUNT_RST);
        run_phase(10, 1'b0, 1'b0);

        drain_results();
        set_config(MODE_TRACE, 1'b1, 1'b0, TRACE_LIMIT_RST, EDGE_COUNT_RST);
        run_phase(10, 1'b0, 1'b0);

        drain_results();
        set_config(MODE_RESERVED, 1'b1, 1'b1, TRACE_LIMIT_RST, EDGE_COUNT_RST);
        run_phase(10, 1'b0, 1'b0);

        drain_results();
        set_config(MODE_COUNT, 1'b1, 1'b1, 17'd0, 13'd8191);
        run_phase(20, 1'b1, 1'b0);

        drain_results();
        set_config(MODE_TRACE, 1'b1, 1'b1, 17'd131071, EDGE_COUNT_RST);
        run_phase(20, 1'b0, 1'b0);

        drain_results();
        set_config(MODE_TRACE, 1'b1, 1'b1, 17'd0, 13'd1);
        run_phase(10, 1'b0, 1'b0);

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
